[rtl/core/cbr_pkg.sv]
// ----------------------------------------------------------------------------
// Checksummed block receiver package
// Shared widths, event codes and the result record of the block receiver.
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 16;
  localparam int EvW   = 3;

  // Acknowledge byte that opens every frame.
  localparam logic [ByteW-1:0] ACK_BYTE = 8'hA5;

  // Largest payload length accepted after reset.
  localparam logic [LenW-1:0] MAX_LENGTH_RESET = 16'hFFFF;

  // Event codes reported with each result.
  localparam logic [EvW-1:0] EV_HEADER   = 3'd0;
  localparam logic [EvW-1:0] EV_DATA     = 3'd1;
  localparam logic [EvW-1:0] EV_GOOD     = 3'd2;
  localparam logic [EvW-1:0] EV_BAD_ACK  = 3'd3;
  localparam logic [EvW-1:0] EV_TOO_LONG = 3'd4;
  localparam logic [EvW-1:0] EV_CK_ERR   = 3'd5;

  // One result item.
  typedef struct packed {
    logic [EvW-1:0]   event_res;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] reply_byte;
    logic [LenW-1:0]  frame_length;
  } cbr_result_t;

endpackage

[rtl/core/cbr_if.sv]
// ----------------------------------------------------------------------------
// Checksummed block receiver channels
// Valid/ready channels for received bytes, results and configuration.
// ----------------------------------------------------------------------------

// Received byte channel.
interface cbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface cbr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  reply_byte;
  logic [15:0] frame_length;

  modport source (output valid, output event_res, output data_byte,
                  output reply_byte, output frame_length, input ready);
  modport sink (input valid, input event_res, input data_byte,
                input reply_byte, input frame_length, output ready);
endinterface

// Configuration write channel for the max_length register.
interface cbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/cbr_frame_fsm.sv]
// ----------------------------------------------------------------------------
// Checksummed block receiver frame state machine
// Holds the deframing state and works out the result for one byte.
// ----------------------------------------------------------------------------
module cbr_frame_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           max_length,
  output cbr_pkg::cbr_result_t  res
);
  import cbr_pkg::*;

  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_LEN_LO  = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  logic [2:0]       phase;
  logic [2:0]       phase_next;
  logic [LenW-1:0]  payload_length;
  logic [LenW-1:0]  payload_length_next;
  logic [LenW-1:0]  bytes_seen;
  logic [LenW-1:0]  bytes_seen_next;
  logic [ByteW-1:0] running_sum;
  logic [ByteW-1:0] running_sum_next;
  logic [LenW-1:0]  decoded_length;
  logic [ByteW-1:0] sum_plus_byte;

  assign decoded_length = {rx_byte, payload_length[ByteW-1:0]};
  assign sum_plus_byte  = running_sum + rx_byte;

  // Next state and result for the byte presented this cycle.
  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    running_sum_next    = running_sum;
    res.event_res       = EV_HEADER;
    res.data_byte       = '0;
    res.reply_byte      = '0;
    unique case (phase)
      PH_LEN_LO: begin
        payload_length_next = {{(LenW-ByteW){1'b0}}, rx_byte};
        running_sum_next    = rx_byte;
        phase_next          = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        payload_length_next = decoded_length;
        running_sum_next    = sum_plus_byte;
        if (decoded_length > max_length) begin
          res.event_res = EV_TOO_LONG;
          phase_next    = PH_WAIT;
        end else if (decoded_length == '0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = sum_plus_byte;
        bytes_seen_next  = bytes_seen + LenW'(1);
        res.event_res    = EV_DATA;
        res.data_byte    = rx_byte;
        if (bytes_seen_next >= payload_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (sum_plus_byte == '0) begin
          res.event_res  = EV_GOOD;
          res.reply_byte = 8'd0 - running_sum;
        end else begin
          res.event_res = EV_CK_ERR;
        end
        phase_next = PH_WAIT;
      end
      default: begin
        // Waiting for the acknowledge byte; unused codes behave the same.
        payload_length_next = '0;
        bytes_seen_next     = '0;
        running_sum_next    = '0;
        if (rx_byte == ACK_BYTE) begin
          phase_next = PH_LEN_LO;
        end else begin
          res.event_res = EV_BAD_ACK;
          phase_next    = PH_WAIT;
        end
      end
    endcase
    res.frame_length = payload_length_next;
  end

  // State registers advance once per byte handed on to the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      payload_length <= '0;
      bytes_seen     <= '0;
      running_sum    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

[rtl/core/checksummed_block_receiver_top.sv]
// ----------------------------------------------------------------------------
// Checksummed block receiver
// Deframes acknowledge, length, payload and checksum bytes from a byte link.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                                          Role
//  in_ch    sink       rx_byte                                          received byte
//  out_ch   source     event_res, data_byte, reply_byte, frame_length   one result per byte
//  cfg      sink       data                                             max_length write
//
// Each accepted byte is held in the input register, which feeds the frame
// state machine; its result is captured in the result register when the
// input stage advances.
// A new byte is taken every cycle while results are being taken; the input
// register acts as a skid stage, so one byte is still accepted while a
// result waits to be taken. Reset is synchronous and clears the frame state,
// sets max_length to 65535 and empties both stages. Configuration writes are always taken.
module checksummed_block_receiver_top (
  input logic       clk,
  input logic       rst,
  cbr_in_if.sink    in_ch,
  cbr_out_if.source out_ch,
  cbr_cfg_if.sink   cfg
);
  import cbr_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             out_valid;
  cbr_result_t      out_res;
  cbr_result_t      step_res;
  logic [LenW-1:0]  max_length;
  logic             advance;

  // The input stage moves on when the result register is free or being taken.
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      max_length <= cfg.data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.rx_byte;
    end
  end

  cbr_frame_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (in_byte),
    .max_length (max_length),
    .res        (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.event_res    = out_res.event_res;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.reply_byte   = out_res.reply_byte;
  assign out_ch.frame_length = out_res.frame_length;

endmodule

[rtl/core/cbr_checker.sv]
// ----------------------------------------------------------------------------
// Checksummed block receiver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cbr_checker (
  input logic  clk,
  input logic  rst,
  input logic  out_valid,
  input logic  out_ready,
  input logic [2:0]  event_res,
  input logic [7:0]  data_byte,
  input logic [7:0]  reply_byte,
  input logic [15:0] frame_length
);
  import cbr_pkg::*;

  // A stalled result keeps its request and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
      $stable(data_byte) && $stable(reply_byte) && $stable(frame_length))
    else $error("result changed while stalled");

  // Only the defined event codes are reported.
  a_ev_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= EV_CK_ERR)
    else $error("undefined event code");

  // The data byte is zero except on a payload event.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_DATA |-> data_byte == '0)
    else $error("data byte set outside a payload event");

  // The reply byte is zero except on a good frame.
  a_reply_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_GOOD |-> reply_byte == '0)
    else $error("reply byte set outside a good frame");

  // A bad acknowledge always reports a cleared length.
  a_bad_ack_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_BAD_ACK |-> frame_length == '0)
    else $error("bad acknowledge with non-zero length");

endmodule

bind checksummed_block_receiver_top cbr_checker u_cbr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .data_byte    (out_ch.data_byte),
  .reply_byte   (out_ch.reply_byte),
  .frame_length (out_ch.frame_length)
);
